/* rtl/lss_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the LIFO stack with search and modify.
package lss_pkg;

	localparam int OP_W   = 3;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int POS_W  = 6;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
	localparam logic [OP_W-1:0] OP_POP     = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
	localparam logic [OP_W-1:0] OP_MODIFY  = 3'd3;
	localparam logic [OP_W-1:0] OP_DISPLAY = 3'd4;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

	// controls broadcast along the cell chain
	typedef struct packed {
		logic push;   // every cell takes the one above
		logic pop;    // every cell takes the one below
		logic rot;    // rotate up, bottom held entry takes the wrap word
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_WALK = 2'b10
	} state_t;

endpackage

/* rtl/lss_cell.sv */
`timescale 1ns / 1ps
// One stack cell: holds a word and trades it with its neighbors.
module lss_cell #(
	parameter int IDX = 0,
	parameter int IW  = 6
) (
	input  logic                               clk,
	input  lss_pkg::cell_ctrl_t                ctrl,
	input  logic [IW-1:0]                      last_idx,
	input  logic signed [lss_pkg::DATA_W-1:0]  above_data,
	input  logic signed [lss_pkg::DATA_W-1:0]  below_data,
	input  logic signed [lss_pkg::DATA_W-1:0]  wrap_data,
	output logic signed [lss_pkg::DATA_W-1:0]  data_q
);
	import lss_pkg::*;

	logic is_bottom;

	// this cell holds the lowest entry in use
	assign is_bottom = (last_idx == IW'(IDX));

	// data move: push shifts down, pop/rotate shift up
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			data_q <= above_data;
		end else if (ctrl.rot && is_bottom) begin
			data_q <= wrap_data;
		end else if (ctrl.pop || ctrl.rot) begin
			data_q <= below_data;
		end
	end

endmodule

/* rtl/lifo_stack_with_search_modify.sv */
`timescale 1ns / 1ps
// LIFO stack with search and modify: top level, a chain of cells with cell 0 on top.
// Push, pop, peek: result valid in the next cycle; one item per cycle if not stalled.
// Modify and display rotate the chain once around the n held entries, one step a cycle
// unless the output stalls: display gives one result beat per step, modify answers
// on the last step. The next item is taken once the walk ends. Reset empties the stack
// and the output; cell contents are not cleared.
module lifo_stack_with_search_modify #(
	parameter int DEPTH = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [lss_pkg::OP_W-1:0]           op,
	input  logic signed [lss_pkg::DATA_W-1:0]  value,
	input  logic signed [lss_pkg::DATA_W-1:0]  match_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [lss_pkg::STAT_W-1:0]         status,
	output logic signed [lss_pkg::DATA_W-1:0]  item_value,
	output logic [lss_pkg::POS_W-1:0]          position,
	output logic                               last_of_run
);
	import lss_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	state_t                    st_q;
	logic [CW-1:0]             count_q;
	logic [IW-1:0]             step_q;
	logic [IW-1:0]             fpos_q;
	logic                      found_q;
	logic                      mod_q;
	logic signed [DATA_W-1:0]  value_q;
	logic signed [DATA_W-1:0]  match_q;
	logic                      out_valid_q;
	logic [STAT_W-1:0]         status_q;
	logic signed [DATA_W-1:0]  item_q;
	logic [POS_W-1:0]          pos_q;
	logic                      last_q;

	logic signed [DATA_W-1:0]  cell_data [DEPTH];
	logic signed [DATA_W-1:0]  top_val;
	logic signed [DATA_W-1:0]  wrap_data;
	logic [IW-1:0]             last_idx;
	cell_ctrl_t                ctrl;

	logic slot_free, acc, empty, full, last_step, hit, adv;
	logic emit;
	logic [STAT_W-1:0]         emit_status;
	logic signed [DATA_W-1:0]  emit_val;
	logic [POS_W-1:0]          emit_pos;
	logic                      emit_last;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (st_q == S_IDLE) && slot_free;
	assign acc       = in_valid && in_ready;
	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(DEPTH));
	assign top_val   = cell_data[0];
	assign last_idx  = IW'(count_q - CW'(1));
	assign last_step = (step_q == last_idx);
	assign hit       = mod_q && !found_q && (top_val == match_q);

	// display waits for the output slot on every step, modify only on its last
	assign adv = (st_q == S_WALK) && (slot_free || (mod_q && !last_step));

	// the top word wraps to the bottom, replaced on the first match
	assign wrap_data = hit ? value_q : top_val;

	always_comb begin
		ctrl.push = acc && (op == OP_PUSH) && !full;
		ctrl.pop  = acc && (op == OP_POP) && !empty;
		ctrl.rot  = adv;
	end

	// cell chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] above_d, below_d;
		if (i == 0) begin : g_top
			assign above_d = value;
		end else begin : g_mid
			assign above_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_bot
			assign below_d = '0;
		end else begin : g_up
			assign below_d = cell_data[i+1];
		end
		lss_cell #(.IDX(i), .IW(IW)) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.last_idx   (last_idx),
			.above_data (above_d),
			.below_data (below_d),
			.wrap_data  (wrap_data),
			.data_q     (cell_data[i])
		);
	end

	// result beat selection
	always_comb begin
		emit        = 1'b0;
		emit_status = ST_OK;
		emit_val    = '0;
		emit_pos    = '0;
		emit_last   = 1'b1;
		if (acc) begin
			case (op)
				OP_PUSH: begin
					emit = 1'b1;
					if (full) begin
						emit_status = ST_FULL;
					end else begin
						emit_val = value;
					end
				end
				OP_POP, OP_PEEK: begin
					emit = 1'b1;
					if (empty) begin
						emit_status = ST_EMPTY;
					end else begin
						emit_val = top_val;
					end
				end
				OP_MODIFY, OP_DISPLAY: begin
					emit        = empty;
					emit_status = ST_EMPTY;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end else if (adv) begin
			if (mod_q) begin
				emit = last_step;
				if (found_q) begin
					emit_val = value_q;
					emit_pos = POS_W'(fpos_q);
				end else if (hit) begin
					emit_val = value_q;
					emit_pos = POS_W'(step_q);
				end else begin
					emit_status = ST_NOTFOUND;
				end
			end else begin
				emit      = 1'b1;
				emit_val  = top_val;
				emit_pos  = POS_W'(step_q);
				emit_last = last_step;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			found_q     <= 1'b0;
			mod_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.push) begin
				count_q <= count_q + CW'(1);
			end else if (ctrl.pop) begin
				count_q <= count_q - CW'(1);
			end
			if (acc && !empty && (op == OP_MODIFY || op == OP_DISPLAY)) begin
				st_q    <= S_WALK;
				step_q  <= '0;
				found_q <= 1'b0;
				mod_q   <= (op == OP_MODIFY);
			end else if (adv) begin
				step_q <= step_q + IW'(1);
				if (hit) begin
					found_q <= 1'b1;
				end
				if (last_step) begin
					st_q <= S_IDLE;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			value_q <= value;
			match_q <= match_value;
		end
		if (adv && hit) begin
			fpos_q <= step_q;
		end
		if (emit) begin
			status_q <= emit_status;
			item_q   <= emit_val;
			pos_q    <= emit_pos;
			last_q   <= emit_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign item_value  = item_q;
	assign position    = pos_q;
	assign last_of_run = last_q;

endmodule

/* rtl/lss_chk.sv */
`timescale 1ns / 1ps
// Port-level checker for the LIFO stack, bound to the top level.
module lss_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic [lss_pkg::OP_W-1:0]           op,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [lss_pkg::STAT_W-1:0]         status,
	input logic signed [lss_pkg::DATA_W-1:0]  item_value,
	input logic [lss_pkg::POS_W-1:0]          position,
	input logic                               last_of_run
);
	import lss_pkg::*;

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(item_value) && $stable(status)
			&& $stable(position) && $stable(last_of_run))
		else $error("result beat changed while stalled");

	// no new item taken while a result is stuck
	a_no_take_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	// push answers in the next cycle
	a_push_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == OP_PUSH |=> out_valid)
		else $error("push result missing");

	// error results are single, zeroed beats
	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last_of_run && item_value == 0 && position == 0)
		else $error("malformed error result");

endmodule

bind lifo_stack_with_search_modify lss_chk u_lss_chk (.*);
